>>> rtl/mpgws_pkg.sv
// Shared types and constants for the multi-panel graphic LCD write sequencer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mpgws_pkg;

	// Most transfers one request can cause, and the width of a count of them.
	localparam int XFER_MAX = 3;
	localparam int CNT_W    = 2;

	typedef enum logic [1:0] {
		ACT_DATA   = 2'd0,
		ACT_MONO   = 2'd1,
		ACT_CMD    = 2'd2,
		ACT_CURSOR = 2'd3
	} action_t;

	// Panel controller command bases and the nibble mask.
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] CMD_PAGE   = 8'h60;
	localparam logic [7:0] NIB_MASK   = 8'h0f;

	// Select pattern with every panel selected (commands are broadcast).
	localparam logic [7:0] SEL_ALL = 8'h00;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data_byte;
		logic        nibble_high;
		logic [7:0]  cursor_x;
		logic [7:0]  cursor_y;
	} req_t;

	typedef struct packed {
		logic [7:0]  select_n;
		logic        is_data;
		logic [7:0]  out_byte;
		logic        last;
	} rsp_t;

	// One byte transfer before the last flag is attached.
	typedef struct packed {
		logic [7:0]  select_n;
		logic        is_data;
		logic [7:0]  out_byte;
	} xfer_t;

	typedef struct packed {
		logic [15:0] pos_x;
		logic [7:0]  pos_y;
	} cursor_t;

endpackage

`default_nettype wire

>>> rtl/mpgws_decode.sv
// Turns one request and the current cursor into its byte transfers and the next cursor.
// Purely combinational; depends on mpgws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpgws_decode import mpgws_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64,
	parameter int REM_W        = $clog2(PANEL_WIDTH)
) (
	input  req_t                       item,
	input  cursor_t                    cur,
	input  logic [REM_W-1:0]           cur_rem,
	output xfer_t [XFER_MAX-1:0]       xfers,
	output logic [CNT_W-1:0]           cnt,
	output cursor_t                    nxt,
	output logic [REM_W-1:0]           nxt_rem
);

	localparam int KX_MAX = 255 / PANEL_WIDTH;
	localparam int PAGES  = (2 * PANEL_HEIGHT) / 8;
	localparam int KP_MAX = 63 / PAGES;

	logic [2:0]       row;
	logic             col;
	logic [2:0]       cs;
	logic [7:0]       dbyte;
	logic [3:0]       nib;
	logic [15:0]      x_inc;
	logic [REM_W:0]   rem_inc;
	logic             edge_hit;
	logic [7:0]       x_base;
	logic [7:0]       c;
	logic [5:0]       pg_src;
	logic [5:0]       pg_base;
	logic [5:0]       pg;

	always_comb begin
		// panel row from y, column from x
		if (16'(cur.pos_y) >= 16'(3 * PANEL_HEIGHT)) begin
			row = 3'd3;
		end else if (16'(cur.pos_y) >= 16'(2 * PANEL_HEIGHT)) begin
			row = 3'd2;
		end else if (16'(cur.pos_y) >= 16'(PANEL_HEIGHT)) begin
			row = 3'd1;
		end else begin
			row = 3'd0;
		end
		col = (cur.pos_x >= 16'(PANEL_WIDTH));
		cs  = 3'((row << 1) | {2'd0, col});

		nib = item.nibble_high ? item.data_byte[7:4] : item.data_byte[3:0];
		for (int i = 0; i < 4; i++) begin
			dbyte[2*i]   = nib[i];
			dbyte[2*i+1] = nib[i];
		end
		if (item.action == ACT_DATA) begin
			dbyte = item.data_byte;
		end

		x_inc    = cur.pos_x + 16'd1;
		rem_inc  = {1'b0, cur_rem} + (REM_W+1)'(1);
		edge_hit = (x_inc == 16'd0) || (rem_inc == (REM_W+1)'(PANEL_WIDTH));

		// cursor_x mod panel width: pick the largest multiple not above it
		x_base = 8'd0;
		for (int k = 1; k <= KX_MAX; k++) begin
			if (16'(item.cursor_x) >= 16'(k * PANEL_WIDTH)) begin
				x_base = 8'(k * PANEL_WIDTH);
			end
		end
		c = item.cursor_x - x_base;

		// page from y, wrapped to the two panel rows the controller addresses
		pg_src  = item.cursor_y[7:2];
		pg_base = 6'd0;
		for (int k = 1; k <= KP_MAX; k++) begin
			if (16'(pg_src) >= 16'(k * PAGES)) begin
				pg_base = 6'(k * PAGES);
			end
		end
		pg = pg_src - pg_base;

		xfers   = '0;
		cnt     = CNT_W'(1);
		nxt     = cur;
		nxt_rem = cur_rem;

		unique case (item.action)
			ACT_DATA, ACT_MONO: begin
				xfers[0] = '{select_n: ~(8'd1 << cs), is_data: 1'b1, out_byte: dbyte};
				xfers[1] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: CMD_COL_LO};
				xfers[2] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: CMD_COL_HI};
				cnt       = edge_hit ? CNT_W'(3) : CNT_W'(1);
				nxt.pos_x = x_inc;
				nxt_rem   = edge_hit ? '0 : rem_inc[REM_W-1:0];
			end
			ACT_CMD: begin
				xfers[0] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: item.data_byte};
			end
			ACT_CURSOR: begin
				xfers[0] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_COL_LO | (c & NIB_MASK)};
				xfers[1] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_COL_HI | ((c >> 4) & NIB_MASK)};
				xfers[2] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_PAGE | {4'd0, pg[3:0]}};
				cnt       = CNT_W'(3);
				nxt.pos_x = {8'd0, item.cursor_x};
				nxt.pos_y = item.cursor_y;
				nxt_rem   = c[REM_W-1:0];
			end
			default: begin
				cnt = CNT_W'(1);
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/multi_panel_glcd_write_sequencer.sv
// Top level of the multi-panel graphic LCD write sequencer.
// Depends on mpgws_pkg and mpgws_decode.
//
// Drives an array of up to eight graphic LCD panels, two wide and four high,
// from a stream of requests. Each request is a data byte, a mono nibble that
// is widened to two bits per pixel, a broadcast command, or a cursor set.
// Every request becomes one to three byte transfers on the xfer channel,
// each with active-low panel selects, a data/command flag and a last flag on
// its final transfer. Data bytes go to the panel under the cursor and advance
// x; landing on a panel edge adds a broadcast column reset (two commands).
// A cursor set loads x and y and broadcasts column and page commands.
// Timing: a request waits in the input register, then its transfers leave
// the result buffer one per cycle while xfer_ready is high. A new request is
// taken while the previous one still drains. There is no configuration.
`timescale 1ns / 1ps
`default_nettype none

module multi_panel_glcd_write_sequencer import mpgws_pkg::*; #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  xfer_valid,
	input  logic  xfer_ready,
	output rsp_t  xfer
);

	localparam int REM_W = $clog2(PANEL_WIDTH);

	// Input register: holds one request until the result buffer takes it.
	req_t                 req_s1;
	logic                 valid_s1;

	// Result buffer: all transfers of one request, drained by index.
	xfer_t [XFER_MAX-1:0] xfers_s2;
	logic [CNT_W-1:0]     cnt_s2;
	logic [CNT_W-1:0]     idx_s2;
	logic                 valid_s2;

	// Cursor, plus x modulo the panel width kept alongside it.
	cursor_t              pos_q;
	logic [REM_W-1:0]     rem_q;

	xfer_t [XFER_MAX-1:0] dec_xfers;
	logic [CNT_W-1:0]     dec_cnt;
	cursor_t              dec_pos;
	logic [REM_W-1:0]     dec_rem;

	logic                 s2_last;
	logic                 s2_free;
	logic                 move;
	xfer_t                cur_xfer;

	mpgws_decode #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.REM_W        (REM_W)
	) u_decode (
		.item    (req_s1),
		.cur     (pos_q),
		.cur_rem (rem_q),
		.xfers   (dec_xfers),
		.cnt     (dec_cnt),
		.nxt     (dec_pos),
		.nxt_rem (dec_rem)
	);

	// The buffer frees up in the cycle its final transfer is taken, so the next
	// request moves in without a bubble.
	assign s2_last   = valid_s2 && (idx_s2 == cnt_s2 - CNT_W'(1));
	assign s2_free   = !valid_s2 || (xfer_ready && s2_last);
	assign move      = valid_s1 && s2_free;
	assign req_ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// Capture the payload only on acceptance; no reset needed.
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Advance the cursor as the request hands its transfers to the buffer, so the
	// next request decodes against the updated position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
			cnt_s2   <= CNT_W'(1);
			pos_q    <= '0;
			rem_q    <= '0;
		end else if (move) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
			cnt_s2   <= dec_cnt;
			pos_q    <= dec_pos;
			rem_q    <= dec_rem;
		end else if (valid_s2 && xfer_ready) begin
			if (s2_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			xfers_s2 <= dec_xfers;
		end
	end

	// Pick the transfer under the drain index.
	always_comb begin
		case (idx_s2)
			2'd0:    cur_xfer = xfers_s2[0];
			2'd1:    cur_xfer = xfers_s2[1];
			2'd2:    cur_xfer = xfers_s2[2];
			default: cur_xfer = xfers_s2[0];
		endcase
	end

	assign xfer_valid    = valid_s2;
	assign xfer.select_n = cur_xfer.select_n;
	assign xfer.is_data  = cur_xfer.is_data;
	assign xfer.out_byte = cur_xfer.out_byte;
	assign xfer.last     = s2_last;

endmodule

`default_nettype wire

>>> sim/multi_panel_glcd_write_sequencer_test.sv
// Self-checking testbench for multi_panel_glcd_write_sequencer.
// Depends on mpgws_pkg and the RTL under rtl/; predicts every byte transfer from the cursor
// it tracks itself and checks each one against the xfer channel in order.
`timescale 1ns / 1ps

module multi_panel_glcd_write_sequencer_test;
	import mpgws_pkg::*;

	localparam int PANEL_W = 128;
	localparam int PANEL_H = 64;
	localparam int HOLD_CYCLES = 150;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		req_t body;
		logic drain_first;	// wait until every predicted transfer is out
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic xfer_valid;
	logic xfer_ready = 1'b0;
	rsp_t xfer;

	pending_t pending_reqs[$];
	rsp_t expected_xfers[$];

	// Cursor as the block should hold it.
	logic [15:0] cur_x = '0;
	logic [7:0] cur_y = '0;

	int xfers_due = 0;
	int xfers_seen = 0;
	int reqs_taken = 0;
	int mismatches = 0;
	int per_action[4] = '{0, 0, 0, 0};
	int edges_predicted = 0;
	int wraps_predicted = 0;
	logic sink_hold = 1'b0;
	logic calm;

	multi_panel_glcd_write_sequencer #(
		.PANEL_WIDTH(PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.xfer_valid(xfer_valid),
		.xfer_ready(xfer_ready),
		.xfer(xfer)
	);

	always #4 clk = ~clk;

	// Stretch where neither side idles.
	assign calm = (reqs_taken >= 60 && reqs_taken < 100);

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// Spread each of four source bits over a 2-bit pixel pair, lowest first.
	function automatic logic [7:0] widen_nibble(input logic [7:0] src, input logic hi);
		logic [3:0] nib;
		logic [7:0] b;
		nib = hi ? src[7:4] : src[3:0];
		for (int i = 0; i < 4; i++)
			b[2*i +: 2] = {2{nib[i]}};
		return b;
	endfunction

	// Work out the transfers one request causes, advance the cursor and queue them.
	task automatic predict_transfers(input req_t r, output int n);
		xfer_t seq [XFER_MAX];
		int row;
		int col;
		int c;
		logic [7:0] b;
		n = 0;
		per_action[r.action]++;
		case (r.action)
			ACT_DATA, ACT_MONO: begin
				b = (r.action == ACT_MONO) ? widen_nibble(r.data_byte, r.nibble_high)
					: r.data_byte;
				row = (cur_y >= 3 * PANEL_H) ? 3 : (cur_y >= 2 * PANEL_H) ? 2 :
					(cur_y >= PANEL_H) ? 1 : 0;
				col = (cur_x >= PANEL_W) ? 1 : 0;
				seq[0] = '{select_n: ~(8'd1 << (2 * row + col)), is_data: 1'b1, out_byte: b};
				n = 1;
				cur_x = cur_x + 16'd1;
				// Landing on a panel edge (a wrap to zero included) resets the column.
				if (cur_x % PANEL_W == 0) begin
					seq[1] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: CMD_COL_LO};
					seq[2] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: CMD_COL_HI};
					n = 3;
					edges_predicted++;
					if (cur_x == 16'd0)
						wraps_predicted++;
				end
			end
			ACT_CMD: begin
				seq[0] = '{select_n: SEL_ALL, is_data: 1'b0, out_byte: r.data_byte};
				n = 1;
			end
			default: begin
				cur_x = {8'd0, r.cursor_x};
				cur_y = r.cursor_y;
				c = r.cursor_x % PANEL_W;
				seq[0] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_COL_LO | (8'(c) & NIB_MASK)};
				seq[1] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_COL_HI | (8'(c >> 4) & NIB_MASK)};
				seq[2] = '{select_n: SEL_ALL, is_data: 1'b0,
					out_byte: CMD_PAGE | 8'((r.cursor_y >> 2) % (2 * PANEL_H / 8))};
				n = 3;
			end
		endcase
		for (int k = 0; k < n; k++)
			expected_xfers.push_back('{select_n: seq[k].select_n, is_data: seq[k].is_data,
				out_byte: seq[k].out_byte, last: (k == n - 1)});
	endtask

	task automatic add_request(input action_t a, input logic [7:0] d, input logic h,
		input logic [7:0] x, input logic [7:0] y, input logic drain);
		pending_t p;
		p.body = '{action: a, data_byte: d, nibble_high: h, cursor_x: x, cursor_y: y};
		p.drain_first = drain;
		pending_reqs.push_back(p);
	endtask

	// Sender: predict on acceptance, then offer the next request or idle.
	always @(posedge clk) begin
		int n_new;
		int due;
		logic holding;
		logic offer;
		pending_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			due = xfers_due;
			holding = req_valid;
			if (req_valid && req_ready) begin
				predict_transfers(req, n_new);
				due = due + n_new;
				reqs_taken <= reqs_taken + 1;
				holding = 1'b0;
			end
			xfers_due <= due;
			offer = holding;
			if (!holding && pending_reqs.size() != 0) begin
				if (!(pending_reqs[0].drain_first && due != xfers_seen)
					&& (calm || $urandom_range(99) >= 12)) begin
					nxt = pending_reqs.pop_front();
					req <= nxt.body;
					offer = 1'b1;
				end
			end
			req_valid <= offer;
		end
	end

	// Receiver: random stalls, none in calm stretches, and stalled throughout the hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			xfer_ready <= 1'b0;
		else
			xfer_ready <= !sink_hold && (calm || $urandom_range(99) >= 12);
	end

	// Check each transfer against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && xfer_valid && xfer_ready) begin
			xfers_seen <= xfers_seen + 1;
			if (expected_xfers.size() == 0) begin
				report_mismatch("transfer with nothing expected, out_byte", xfer.out_byte, 8'hxx);
			end else begin
				want = expected_xfers.pop_front();
				if (xfer.select_n !== want.select_n)
					report_mismatch("select_n", xfer.select_n, want.select_n);
				if (xfer.is_data !== want.is_data)
					report_mismatch("is_data", {7'd0, xfer.is_data}, {7'd0, want.is_data});
				if (xfer.out_byte !== want.out_byte)
					report_mismatch("out_byte", xfer.out_byte, want.out_byte);
				if (xfer.last !== want.last)
					report_mismatch("last", {7'd0, xfer.last}, {7'd0, want.last});
			end
		end
	end

	// Hold the receiver off long enough for the block to fill and stall its input.
	initial begin
		do @(posedge clk); while (reqs_taken < 40);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#200_000;
		$display("Timeout with %0d transfers still outstanding", xfers_due - xfers_seen);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int pick;
		action_t act;
		logic [7:0] x;

		// Directed: data and mono at the home cursor, commands, then one panel at a time.
		add_request(ACT_DATA, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_DATA, 8'hff, 1'b1, 8'hff, 8'hff, 1'b0);
		add_request(ACT_MONO, 8'ha5, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_MONO, 8'ha5, 1'b1, 8'h00, 8'h00, 1'b0);
		add_request(ACT_MONO, 8'h0f, 1'b0, 8'hff, 8'h00, 1'b0);
		add_request(ACT_MONO, 8'h0f, 1'b1, 8'h00, 8'hff, 1'b1);
		add_request(ACT_CMD, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CMD, 8'hff, 1'b1, 8'hff, 8'hff, 1'b0);
		// Last column of the left panel: next data lands on the edge.
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd127, 8'd63, 1'b0);
		add_request(ACT_DATA, 8'h5a, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_DATA, 8'h3c, 1'b1, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'h00, 1'b1, 8'd0, 8'd64, 1'b0);
		add_request(ACT_DATA, 8'h81, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'hff, 1'b0, 8'd128, 8'd127, 1'b1);
		add_request(ACT_DATA, 8'h7e, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd0, 8'd128, 1'b0);
		add_request(ACT_MONO, 8'hf0, 1'b1, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd200, 8'd191, 1'b0);
		add_request(ACT_DATA, 8'h01, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd0, 8'd192, 1'b0);
		add_request(ACT_DATA, 8'h80, 1'b0, 8'h00, 8'h00, 1'b0);
		// Far corner: right column, bottom row, highest page; data then runs past both panels.
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd255, 8'd255, 1'b0);
		add_request(ACT_DATA, 8'hc3, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_DATA, 8'h24, 1'b0, 8'h00, 8'h00, 1'b0);
		add_request(ACT_CURSOR, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0);

		// Random mix, cursor sets biased toward panel edges.
		for (int i = 0; i < 100; i++) begin
			pick = $urandom_range(99);
			act = (pick < 40) ? ACT_DATA : (pick < 60) ? ACT_MONO :
				(pick < 75) ? ACT_CMD : ACT_CURSOR;
			case ($urandom_range(4))
				0: x = 8'(PANEL_W - 1);
				1: x = 8'(PANEL_W - 2);
				2: x = 8'(2 * PANEL_W - 1);
				default: x = 8'($urandom);
			endcase
			add_request(act, 8'($urandom), 1'($urandom), x, 8'($urandom), i == 70);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_valid || xfers_seen < xfers_due);
		repeat (20) @(negedge clk);

		while (expected_xfers.size() != 0)
			report_mismatch("transfer never arrived, out_byte", 8'hxx,
				expected_xfers.pop_front().out_byte);

		$display("Covered %0d requests: %0d data, %0d mono, %0d command, %0d cursor set",
			per_action[0] + per_action[1] + per_action[2] + per_action[3],
			per_action[ACT_DATA], per_action[ACT_MONO], per_action[ACT_CMD],
			per_action[ACT_CURSOR]);
		$display("%0d transfers checked, %0d panel-edge column resets, %0d x wraps, %0d mismatches",
			xfers_seen, edges_predicted, wraps_predicted, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
